// File: hdl/wpm_pkg.sv
// Shared constants, types and character helpers for the wildcard pattern matcher.
// No dependencies; imported by every design module of the block (the checker does not import it).
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

  localparam int MAX_PATTERN = 32;
  // Counter/length width holds 0..MAX_PATTERN inclusive.
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [8:0] CASE_GAP = 9'd32;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  // Control handed to the column unit for one sweep step.
  typedef struct packed {
    logic       step;   // advance the column ring by one position
    logic       adv;    // 1: text advance, 0: rebuild start column
    logic       first;  // position zero of the sweep
    logic       live;   // position lies within the loaded pattern
    logic [7:0] ch;     // text byte under test
  } wpm_ctl_t;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
               ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  // Equal, or apart by exactly 32, compared without wrap.
  function automatic logic char_eq(input logic [7:0] c, input logic [7:0] p);
    logic [8:0] cw;
    logic [8:0] pw;
    cw = {1'b0, c};
    pw = {1'b0, p};
    char_eq = (cw == pw) || ((cw + CASE_GAP) == pw) || (cw == (pw + CASE_GAP));
  endfunction

endpackage

`default_nettype wire

// File: hdl/wpm_pat_ram.sv
// Pattern store: one write port, one registered read port.
// Depends on wpm_pkg for depth and address width.
`timescale 1ns / 1ps
`default_nettype none

module wpm_pat_ram
  import wpm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [MAX_PATTERN];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/wpm_col_unit.sv
// Match column held as a rotating ring with one shared cell evaluated per step.
// Depends on wpm_pkg (wpm_ctl_t, character helpers).
`timescale 1ns / 1ps
`default_nettype none

module wpm_col_unit
  import wpm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire wpm_ctl_t ctl,
  input  wire logic [7:0] pat_byte,   // pattern byte for position k-1
  output logic          new_bit       // new column bit for position k
);

  // Ring: at rest col_r[j] is bit j; each step retires the head and
  // inserts the fresh bit at the top, so MAX_PATTERN+1 steps realign it.
  logic [MAX_PATTERN:0] col_r;
  logic                 prev_r;   // old bit k-1
  logic                 cur_r;    // new bit k-1
  logic                 old_bit;
  logic                 alnum;

  assign old_bit = col_r[0];
  assign alnum   = is_alnum(ctl.ch);

  always_comb begin
    new_bit = 1'b0;
    if (ctl.first) begin
      new_bit = ~ctl.adv;
    end else if (!ctl.live) begin
      new_bit = ctl.adv ? old_bit : 1'b0;
    end else if (!ctl.adv) begin
      new_bit = cur_r && (pat_byte == CH_STAR);
    end else if (pat_byte == CH_QUERY) begin
      new_bit = alnum && prev_r;
    end else if (pat_byte == CH_STAR) begin
      new_bit = cur_r || (alnum && old_bit);
    end else begin
      new_bit = char_eq(ctl.ch, pat_byte) && prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= (MAX_PATTERN + 1)'(1);
    end else if (ctl.step) begin
      col_r <= {new_bit, col_r[MAX_PATTERN:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prev_r <= old_bit;
      cur_r  <= new_bit;
    end
  end

endmodule

`default_nettype wire

// File: hdl/wildcard_pattern_matcher.sv
// Top level of the glob-style wildcard matcher: sequencer, pattern length, output slot.
// Depends on wpm_pkg, wpm_pat_ram and wpm_col_unit.
//
// Usage
//   Input stream (in_*): in_tuser = 0 loads a pattern byte, 1 sends a text byte.
//   in_tdata carries the byte, in_tlast marks the last byte of pattern or text.
//   A pattern byte after a closed pattern starts a new one. A text byte that
//   arrives while a pattern is still open closes it first.
//   Result stream (out_*): one item per text, on its last byte:
//   bit 0 matched, bit 1 pattern overflow (more than MAX_PATTERN bytes).
// Sequencing
//   Pattern byte: written on accept; the last one adds a start-column sweep.
//   Text byte: after the accept, a sweep over the whole ring, one ring position
//   per cycle through the shared cell; a byte that also closes the pattern is
//   preceded by a start-column sweep.
//   Last text byte: the sweep makes the result decision, the output slot is
//   loaded once it is free, then the start column is rebuilt.
//   in_tready is high only while the sequencer is idle.
// Reset
//   Synchronous, active low: empty pattern, loading expected, no result pending.
// Back-pressure
//   The result waits in the output register; further items are still taken,
//   but the next result waits in the sequencer until the slot frees.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_pattern_matcher
  import wpm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] char_byte
  input  wire logic       in_tuser,    // [0] req_type
  input  wire logic       in_tlast,    // is_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_ADV   = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  localparam logic [LEN_W-1:0] LAST_POS = LEN_W'(MAX_PATTERN);

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             loading_r, loading_nxt;
  logic             adv_pend_r, adv_pend_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic             last_r, last_nxt;
  logic             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_match_r, out_match_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             accept;
  logic [LEN_W-1:0] base_len;
  logic             wr_en;
  logic [7:0]       pat_byte;
  logic             new_bit;
  wpm_ctl_t         ctl;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  // A pattern byte after a closed pattern restarts the length.
  assign base_len  = loading_r ? len_r : '0;
  assign wr_en     = accept && (in_tuser == REQ_PATTERN) && (base_len < LAST_POS);

  assign ctl.step  = (state_r == ST_START) || (state_r == ST_ADV);
  assign ctl.adv   = (state_r == ST_ADV);
  assign ctl.first = (k_r == '0);
  assign ctl.live  = (k_r != '0) && (k_r <= len_r);
  assign ctl.ch    = ch_r;

  wpm_pat_ram u_pat_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (base_len[ADDR_W-1:0]),
    .wr_data (in_tdata),
    .rd_addr (k_r[ADDR_W-1:0]),   // data lands for the next position
    .rd_data (pat_byte)
  );

  wpm_col_unit u_col_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .pat_byte (pat_byte),
    .new_bit  (new_bit)
  );

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    loading_nxt   = loading_r;
    adv_pend_nxt  = adv_pend_r;
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_match_nxt = out_match_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          k_nxt = '0;
          if (in_tuser == REQ_PATTERN) begin
            loading_nxt = 1'b1;
            ovf_nxt     = loading_r ? ovf_r : 1'b0;
            if (base_len < LAST_POS) begin
              len_nxt = base_len + 1'b1;
            end else begin
              len_nxt = base_len;
              ovf_nxt = 1'b1;
            end
            if (in_tlast) begin
              loading_nxt  = 1'b0;
              adv_pend_nxt = 1'b0;
              state_nxt    = ST_START;
            end
          end else begin
            ch_nxt   = in_tdata;
            last_nxt = in_tlast;
            if (loading_r) begin
              // Open pattern: close it and build its start column first.
              loading_nxt  = 1'b0;
              adv_pend_nxt = 1'b1;
              state_nxt    = ST_START;
            end else begin
              state_nxt = ST_ADV;
            end
          end
        end
      end
      ST_START: begin
        k_nxt = k_r + 1'b1;
        if (k_r == LAST_POS) begin
          k_nxt        = '0;
          adv_pend_nxt = 1'b0;
          state_nxt    = adv_pend_r ? ST_ADV : ST_IDLE;
        end
      end
      ST_ADV: begin
        k_nxt = k_r + 1'b1;
        if (k_r == len_r) begin
          res_nxt = new_bit;
        end
        if (k_r == LAST_POS) begin
          k_nxt     = '0;
          state_nxt = last_r ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = res_r && !ovf_r;
          out_ovf_nxt   = ovf_r;
          k_nxt         = '0;
          adv_pend_nxt  = 1'b0;
          state_nxt     = ST_START;   // next text starts from a fresh column
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      loading_r   <= 1'b1;
      adv_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      loading_r   <= loading_nxt;
      adv_pend_r  <= adv_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r        <= ch_nxt;
    last_r      <= last_nxt;
    res_r       <= res_nxt;
    out_match_r <= out_match_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_ovf_r, out_match_r};

endmodule

`default_nettype wire

// File: hdl/wpm_checker.sv
// Port-level checks for the wildcard pattern matcher, bound to the top level.
// Depends on wildcard_pattern_matcher port names only.
`timescale 1ns / 1ps
`default_nettype none

module wpm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Overflow forces a mismatch.
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("match reported with pattern overflow");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:2] == 6'b0))
    else $error("result padding not zero");

  // A text item always starts a column sweep, so the block goes busy.
  a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("ready after text item");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
